[design/cirt_pkg.sv]
// cirt_pkg: shared constants, codes and types of the connection id remap table
// used by cirt_store, cirt_ctrl and connection_id_remap_table
`default_nettype none

package cirt_pkg;

  localparam int unsigned ENTRIES_DEF = 64;
  localparam int unsigned DEVICES     = 8;
  localparam int unsigned ID_BASE     = 100;

  localparam int unsigned DEV_W  = 3;
  localparam int unsigned CONN_W = 32;
  localparam int unsigned UID_W  = 8;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_KNOWN   = 3'd1,
    ST_UNKNOWN = 3'd2,
    ST_FULL    = 3'd3,
    ST_MISS    = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_LOOK,
    S_FIN
  } state_e;

  typedef struct packed {
    logic              valid;
    logic [DEV_W-1:0]  device;
    logic [CONN_W-1:0] dev_id;
  } entry_t;

  typedef struct packed {
    logic              deliver;
    logic [UID_W-1:0]  user_id;
    status_e           status;
    logic [DEV_W-1:0]  found_device;
    logic [CONN_W-1:0] found_dev_link_id;
  } result_t;

endpackage

`default_nettype wire

[design/cirt_store.sv]
// cirt_store: entry memory, one write port and one registered read port
// depends on cirt_pkg for the entry layout
`default_nettype none

module cirt_store import cirt_pkg::*; #(
  parameter int unsigned ENTRIES = ENTRIES_DEF,
  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [IW-1:0] waddr_i,
  input  entry_t        wdata_i,
  input  logic          re_i,
  input  logic [IW-1:0] raddr_i,
  output entry_t        rdata_o
);

  entry_t mem_q [ENTRIES];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[design/cirt_ctrl.sv]
// cirt_ctrl: sequencer with one shared pair comparator that walks the entry memory
// depends on cirt_pkg; drives cirt_store and hands results to the output register
`default_nettype none

module cirt_ctrl import cirt_pkg::*; #(
  parameter int unsigned ENTRIES = ENTRIES_DEF,
  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  localparam int unsigned CW = $clog2(ENTRIES + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              func_i,
  input  logic [DEV_W-1:0]  device_index_i,
  input  logic [CONN_W-1:0] dev_link_id_i,
  input  logic              link_up_i,
  input  logic              link_down_i,
  input  logic [CONN_W-1:0] query_user_id_i,
  output logic              mem_we_o,
  output logic [IW-1:0]     mem_waddr_o,
  output entry_t            mem_wdata_o,
  output logic              mem_re_o,
  output logic [IW-1:0]     mem_raddr_o,
  input  entry_t            mem_rdata_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output result_t           res_o
);

  state_e            state_q, state_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic              pend_q, pend_d;
  logic [IW-1:0]     pidx_q;
  logic              hit_q, hit_d, free_q, free_d;
  logic [IW-1:0]     hidx_q, hidx_d, fidx_q, fidx_d;
  logic              func_q, conn_q, disc_q, in_range_q;
  logic [DEV_W-1:0]  dev_q;
  logic [CONN_W-1:0] id_q, query_q;
  result_t           res_q, res_d;

  logic              accept, dev_ok, in_range, scan_last, is_match;
  logic [CONN_W-1:0] q_off;
  logic [UID_W-1:0]  uid_hit, uid_free;

  assign accept    = in_valid_i && in_ready_o;
  assign dev_ok    = 32'(device_index_i) < DEVICES;
  assign q_off     = query_user_id_i - CONN_W'(ID_BASE);
  assign in_range  = (query_user_id_i >= CONN_W'(ID_BASE)) && ({1'b0, q_off} < 33'(ENTRIES));
  assign scan_last = cnt_q == CW'(ENTRIES);
  assign uid_hit   = UID_W'(ID_BASE + 32'(hidx_q));
  assign uid_free  = UID_W'(ID_BASE + 32'(fidx_q));

  // shared pair comparator
  assign is_match = mem_rdata_i.valid && (mem_rdata_i.device == dev_q) &&
                    (mem_rdata_i.dev_id == id_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (cnt_q == CW'(ENTRIES - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          if (func_i) state_d = S_LOOK;
          else if (dev_ok) state_d = S_SCAN;
          else state_d = S_FIN;
        end
      end
      S_SCAN: begin
        if (scan_last) state_d = S_DECIDE;
      end
      S_DECIDE: state_d = S_FIN;
      S_LOOK:   state_d = S_FIN;
      S_FIN: begin
        if (res_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = state_q == S_IDLE;
    res_valid_o = state_q == S_FIN;
    mem_we_o    = 1'b0;
    mem_waddr_o = cnt_q[IW-1:0];
    mem_wdata_o = '0;
    mem_re_o    = 1'b0;
    mem_raddr_o = cnt_q[IW-1:0];
    case (state_q)
      S_CLEAR: mem_we_o = 1'b1;
      S_IDLE: begin
        mem_re_o    = accept && func_i && in_range;
        mem_raddr_o = q_off[IW-1:0];
      end
      S_SCAN: mem_re_o = !scan_last;
      S_DECIDE: begin
        if (hit_q && disc_q) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = hidx_q;
        end else if (conn_q && !hit_q && free_q && !disc_q) begin
          mem_we_o           = 1'b1;
          mem_waddr_o        = fidx_q;
          mem_wdata_o.valid  = 1'b1;
          mem_wdata_o.device = dev_q;
          mem_wdata_o.dev_id = id_q;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    cnt_d  = cnt_q;
    pend_d = 1'b0;
    hit_d  = hit_q;
    hidx_d = hidx_q;
    free_d = free_q;
    fidx_d = fidx_q;
    res_d  = res_q;
    case (state_q)
      S_CLEAR: cnt_d = cnt_q + CW'(1);
      S_IDLE: begin
        cnt_d  = '0;
        hit_d  = 1'b0;
        free_d = 1'b0;
        if (accept && !func_i && !dev_ok) begin
          res_d        = '0;
          res_d.status = ST_UNKNOWN;
        end
      end
      S_SCAN: begin
        if (!scan_last) begin
          cnt_d  = cnt_q + CW'(1);
          pend_d = 1'b1;
        end
        if (pend_q) begin
          if (is_match && !hit_q) begin
            hit_d  = 1'b1;
            hidx_d = pidx_q;
          end
          if (!mem_rdata_i.valid && !free_q) begin
            free_d = 1'b1;
            fidx_d = pidx_q;
          end
        end
      end
      S_DECIDE: begin
        res_d = '0;
        if (hit_q) begin
          res_d.deliver = 1'b1;
          res_d.user_id = uid_hit;
          res_d.status  = conn_q ? ST_KNOWN : ST_OK;
        end else if (!conn_q) begin
          res_d.status = ST_UNKNOWN;
        end else if (free_q) begin
          res_d.deliver = 1'b1;
          res_d.user_id = uid_free;
        end else begin
          res_d.status = ST_FULL;
        end
      end
      S_LOOK: begin
        res_d = '0;
        if (in_range_q && mem_rdata_i.valid) begin
          res_d.deliver           = 1'b1;
          res_d.user_id           = query_q[UID_W-1:0];
          res_d.found_device      = mem_rdata_i.device;
          res_d.found_dev_link_id = mem_rdata_i.dev_id;
        end else begin
          res_d.status = ST_MISS;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      cnt_q   <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pidx_q <= cnt_q[IW-1:0];
    hit_q  <= hit_d;
    hidx_q <= hidx_d;
    free_q <= free_d;
    fidx_q <= fidx_d;
    res_q  <= res_d;
    if (accept) begin
      func_q     <= func_i;
      dev_q      <= device_index_i;
      id_q       <= dev_link_id_i;
      conn_q     <= link_up_i;
      disc_q     <= link_down_i;
      query_q    <= query_user_id_i;
      in_range_q <= in_range;
    end
  end

  assign res_o = res_q;

  a_write_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we_o |-> (state_q == S_CLEAR || state_q == S_DECIDE))
    else $error("memory written outside clear pass or decision");

  a_scan_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !func_i && dev_ok) |=> (state_q == S_SCAN && cnt_q == '0 && !hit_q && !free_q))
    else $error("event scan did not start clean");

  a_drop_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && (res_q.status == ST_UNKNOWN || res_q.status == ST_FULL ||
                     res_q.status == ST_MISS))
    |-> (!res_q.deliver && res_q.user_id == '0 && res_q.found_dev_link_id == '0))
    else $error("dropped beat carries data");

  a_lookup_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_q.found_device != '0) |-> func_q)
    else $error("event beat carries a found device");

endmodule

`default_nettype wire

[design/connection_id_remap_table.sv]
// connection_id_remap_table: top level, sequencer, entry memory and output register
// depends on cirt_pkg, cirt_ctrl and cirt_store
//
//   channel  handshake              payload
//   in       in_valid_i/in_ready_o  func, device_index, dev_link_id, link_up,
//                                   link_down, query_user_id
//   out      out_valid_o/out_ready_i deliver, user_id, status, found_device,
//                                   found_dev_link_id
//
// a device event with a valid device index is resolved by the single comparator
// walking the entry memory one entry per cycle
// a reverse lookup reads at most one memory entry
// after reset a clearing pass writes every entry before the first beat is taken
// the output register holds a result while the next input beat is taken; a new
// result waits until that register is free
`default_nettype none

module connection_id_remap_table import cirt_pkg::*; #(
  parameter int unsigned ENTRIES = ENTRIES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              func_i,
  input  logic [DEV_W-1:0]  device_index_i,
  input  logic [CONN_W-1:0] dev_link_id_i,
  input  logic              link_up_i,
  input  logic              link_down_i,
  input  logic [CONN_W-1:0] query_user_id_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              deliver_o,
  output logic [UID_W-1:0]  user_id_o,
  output logic [2:0]        status_o,
  output logic [DEV_W-1:0]  found_device_o,
  output logic [CONN_W-1:0] found_dev_link_id_o
);

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic          mem_we, mem_re;
  logic [IW-1:0] mem_waddr, mem_raddr;
  entry_t        mem_wdata, mem_rdata;
  logic          res_valid, res_ready;
  result_t       res;
  logic          out_valid_q, out_valid_d;
  result_t       out_q;

  cirt_ctrl #(
    .ENTRIES (ENTRIES)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .func_i          (func_i),
    .device_index_i  (device_index_i),
    .dev_link_id_i   (dev_link_id_i),
    .link_up_i       (link_up_i),
    .link_down_i     (link_down_i),
    .query_user_id_i (query_user_id_i),
    .mem_we_o        (mem_we),
    .mem_waddr_o     (mem_waddr),
    .mem_wdata_o     (mem_wdata),
    .mem_re_o        (mem_re),
    .mem_raddr_o     (mem_raddr),
    .mem_rdata_i     (mem_rdata),
    .res_valid_o     (res_valid),
    .res_ready_i     (res_ready),
    .res_o           (res)
  );

  cirt_store #(
    .ENTRIES (ENTRIES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign res_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign deliver_o           = out_q.deliver;
  assign user_id_o           = out_q.user_id;
  assign status_o            = out_q.status;
  assign found_device_o      = out_q.found_device;
  assign found_dev_link_id_o = out_q.found_dev_link_id;

endmodule

`default_nettype wire

[bench/testbench.sv]
// testbench for connection_id_remap_table: directed and random device events and
// reverse lookups checked against an in-bench model of the remap table
// depends on cirt_pkg and connection_id_remap_table
`timescale 1ns / 100ps

module testbench;
  import cirt_pkg::*;

  localparam int unsigned ENTRIES     = ENTRIES_DEF;
  localparam int          STALL_LIMIT = 3000;
  localparam int          HOLD_CYCLES = 400;
  localparam int          HOLD_AT     = 300;
  localparam int          POOL_MAX    = 96;
  localparam logic        FUNC_EVENT  = 1'b0;
  localparam logic        FUNC_LOOKUP = 1'b1;

  typedef struct {
    logic              func;
    logic [DEV_W-1:0]  dev;
    logic [CONN_W-1:0] conn_id;
    logic              conn;
    logic              disc;
    logic [CONN_W-1:0] query;
  } remap_req_t;

  typedef enum {ROUND_FILL, ROUND_CHURN, ROUND_DRAIN} round_e;
  typedef enum {
    ACT_CONNECT_NEW, ACT_CONNECT_OLD, ACT_EVENT_OLD, ACT_DROP_OLD,
    ACT_UNKNOWN, ACT_LOOKUP, ACT_NOISE
  } action_e;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic              func_i = 1'b0;
  logic [DEV_W-1:0]  device_index_i = '0;
  logic [CONN_W-1:0] dev_link_id_i = '0;
  logic              link_up_i = 1'b0;
  logic              link_down_i = 1'b0;
  logic [CONN_W-1:0] query_user_id_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic              deliver_o;
  logic [UID_W-1:0]  user_id_o;
  logic [2:0]        status_o;
  logic [DEV_W-1:0]  found_device_o;
  logic [CONN_W-1:0] found_dev_link_id_o;

  logic              tbl_valid [ENTRIES];
  logic [DEV_W-1:0]  tbl_dev   [ENTRIES];
  logic [CONN_W-1:0] tbl_conn  [ENTRIES];

  remap_req_t        pending_q [$];
  result_t           remap_expect_q [$];
  logic [DEV_W-1:0]  pool_dev [$];
  logic [CONN_W-1:0] pool_id  [$];

  remap_req_t tx_cur;
  remap_req_t tx_next;
  logic       tx_fire;
  result_t    rx_exp;
  int         n_sent = 0;
  int         n_recv = 0;
  int         n_total = 0;
  int         n_err = 0;
  int         tx_gap = 0;
  int         rx_gap = 0;
  int         hold_cnt = 0;
  bit         hold_done = 1'b0;
  int         stall_cycles = 0;
  logic       tx_idle_ok;
  logic       rx_idle_ok;

  connection_id_remap_table #(
    .ENTRIES(ENTRIES)
  ) i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .func_i             (func_i),
    .device_index_i     (device_index_i),
    .dev_link_id_i      (dev_link_id_i),
    .link_up_i          (link_up_i),
    .link_down_i        (link_down_i),
    .query_user_id_i    (query_user_id_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .deliver_o          (deliver_o),
    .user_id_o          (user_id_o),
    .status_o           (status_o),
    .found_device_o     (found_device_o),
    .found_dev_link_id_o(found_dev_link_id_o)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  function automatic result_t remap_predict(remap_req_t req);
    result_t     res;
    int          hit;
    bit          full;
    int unsigned ofs;
    res  = '0;
    hit  = -1;
    full = 1'b0;
    if (req.func == FUNC_LOOKUP) begin
      ofs = req.query - ID_BASE;
      if (req.query >= ID_BASE && ofs < ENTRIES && tbl_valid[ofs]) begin
        res.deliver           = 1'b1;
        res.user_id           = req.query[UID_W-1:0];
        res.status            = ST_OK;
        res.found_device      = tbl_dev[ofs];
        res.found_dev_link_id = tbl_conn[ofs];
      end else begin
        res.status = ST_MISS;
      end
    end else if (req.dev >= DEVICES) begin
      res.status = ST_UNKNOWN;
    end else begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (hit < 0 && tbl_valid[i] && tbl_dev[i] == req.dev && tbl_conn[i] == req.conn_id)
          hit = i;
      end
      if (req.conn) begin
        if (hit >= 0) begin
          res.status = ST_KNOWN;
        end else begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (hit < 0 && !tbl_valid[i]) hit = i;
          end
          if (hit >= 0) begin
            tbl_valid[hit] = 1'b1;
            tbl_dev[hit]   = req.dev;
            tbl_conn[hit]  = req.conn_id;
          end else begin
            full = 1'b1;
          end
        end
      end
      if (full) begin
        res.status = ST_FULL;
      end else if (hit < 0) begin
        res.status = ST_UNKNOWN;
      end else begin
        res.deliver = 1'b1;
        res.user_id = UID_W'(ID_BASE + hit);
        if (req.disc) tbl_valid[hit] = 1'b0;
      end
    end
    return res;
  endfunction

  task automatic push_req(input logic f, input logic [DEV_W-1:0] d, input logic [CONN_W-1:0] c,
                          input logic cn, input logic dc, input logic [CONN_W-1:0] q);
    remap_req_t req;
    req.func    = f;
    req.dev     = d;
    req.conn_id = c;
    req.conn    = cn;
    req.disc    = dc;
    req.query   = q;
    pending_q = {pending_q, req};
  endtask

  function automatic logic [CONN_W-1:0] rand_conn_id();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 15);
      1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [CONN_W-1:0] rand_query();
    if ($urandom_range(0, 99) < 85) return $urandom_range(96, 168);
    return $urandom;
  endfunction

  task automatic make_pair(output logic [DEV_W-1:0] d, output logic [CONN_W-1:0] c);
    int idx;
    d = DEV_W'($urandom_range(0, 7));
    c = rand_conn_id();
    pool_dev = {pool_dev, d};
    pool_id  = {pool_id, c};
    if (pool_dev.size() > POOL_MAX) begin
      idx = $urandom_range(0, pool_dev.size() - 1);
      pool_dev.delete(idx);
      pool_id.delete(idx);
    end
  endtask

  task automatic pick_pair(output logic [DEV_W-1:0] d, output logic [CONN_W-1:0] c);
    int idx;
    if (pool_dev.size() == 0) begin
      make_pair(d, c);
    end else begin
      idx = $urandom_range(0, pool_dev.size() - 1);
      d   = pool_dev[idx];
      c   = pool_id[idx];
    end
  endtask

  task automatic add_round(input round_e kind, input int count);
    int                pct;
    action_e           act;
    logic              f;
    logic [DEV_W-1:0]  d;
    logic [CONN_W-1:0] c;
    logic              cn;
    logic              dc;
    logic [CONN_W-1:0] q;
    for (int n = 0; n < count; n++) begin
      pct = $urandom_range(0, 99);
      case (kind)
        ROUND_FILL: begin
          if (pct < 70) act = ACT_CONNECT_NEW;
          else if (pct < 85) act = ACT_EVENT_OLD;
          else act = ACT_LOOKUP;
        end
        ROUND_CHURN: begin
          if (pct < 20) act = ACT_CONNECT_NEW;
          else if (pct < 35) act = ACT_CONNECT_OLD;
          else if (pct < 60) act = ACT_EVENT_OLD;
          else if (pct < 80) act = ACT_LOOKUP;
          else if (pct < 90) act = ACT_UNKNOWN;
          else act = ACT_NOISE;
        end
        default: begin
          if (pct < 60) act = ACT_DROP_OLD;
          else if (pct < 80) act = ACT_LOOKUP;
          else if (pct < 90) act = ACT_CONNECT_NEW;
          else act = ACT_NOISE;
        end
      endcase
      f  = FUNC_EVENT;
      cn = 1'b0;
      dc = 1'b0;
      q  = $urandom;
      case (act)
        ACT_CONNECT_NEW: begin
          make_pair(d, c);
          cn = 1'b1;
          dc = (kind == ROUND_CHURN) && ($urandom_range(0, 5) == 0);
        end
        ACT_CONNECT_OLD: begin
          pick_pair(d, c);
          cn = 1'b1;
          dc = ($urandom_range(0, 3) == 0);
        end
        ACT_EVENT_OLD: begin
          pick_pair(d, c);
          dc = ($urandom_range(0, 2) == 0);
        end
        ACT_DROP_OLD: begin
          pick_pair(d, c);
          dc = 1'b1;
          cn = ($urandom_range(0, 7) == 0);
        end
        ACT_UNKNOWN: begin
          d  = DEV_W'($urandom_range(0, 7));
          c  = $urandom;
          dc = 1'($urandom_range(0, 1));
        end
        ACT_LOOKUP: begin
          f  = FUNC_LOOKUP;
          d  = DEV_W'($urandom_range(0, 7));
          c  = $urandom;
          cn = 1'($urandom_range(0, 1));
          dc = 1'($urandom_range(0, 1));
          q  = rand_query();
        end
        default: begin
          f  = 1'($urandom_range(0, 1));
          d  = DEV_W'($urandom_range(0, 7));
          c  = $urandom;
          cn = 1'($urandom_range(0, 1));
          dc = 1'($urandom_range(0, 1));
        end
      endcase
      push_req(f, d, c, cn, dc, q);
    end
  endtask

  assign tx_idle_ok = (hold_cnt == 0) && !(n_sent >= 700 && n_sent < 900)
                      && (n_sent + 200 < n_total);
  assign rx_idle_ok = !(n_recv >= 1100 && n_recv < 1300) && (n_recv + 200 < n_total);

  // input side: one beat per pending item, random gaps between beats
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      tx_gap     <= 0;
      n_sent     <= 0;
    end else begin
      tx_fire = in_valid_i && in_ready_o;
      if (tx_fire) begin
        remap_expect_q = {remap_expect_q, remap_predict(tx_cur)};
        n_sent <= n_sent + 1;
      end
      if (!in_valid_i || tx_fire) begin
        if (tx_fire && tx_idle_ok && $urandom_range(0, 99) < 20) begin
          tx_gap     <= $urandom_range(0, 14);
          in_valid_i <= 1'b0;
        end else if (tx_gap != 0) begin
          tx_gap     <= tx_gap - 1;
          in_valid_i <= 1'b0;
        end else if (pending_q.size() != 0) begin
          tx_next          = pending_q.pop_front();
          tx_cur          <= tx_next;
          func_i          <= tx_next.func;
          device_index_i  <= tx_next.dev;
          dev_link_id_i   <= tx_next.conn_id;
          link_up_i       <= tx_next.conn;
          link_down_i     <= tx_next.disc;
          query_user_id_i <= tx_next.query;
          in_valid_i      <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off so the block fills up and stalls its input
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_cnt  <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && n_sent >= HOLD_AT) begin
      hold_cnt  <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  // output side: compare each result beat with the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      rx_gap      <= 0;
      n_recv      <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        n_recv <= n_recv + 1;
        if (remap_expect_q.size() == 0) begin
          n_err = n_err + 1;
          if (n_err <= 10)
            $display("result beat %0d with no prediction pending: deliver=%0d user_id=%0d",
                     n_recv, deliver_o, user_id_o);
        end else begin
          rx_exp = remap_expect_q.pop_front();
          if (deliver_o !== rx_exp.deliver || user_id_o !== rx_exp.user_id
              || status_o !== rx_exp.status || found_device_o !== rx_exp.found_device
              || found_dev_link_id_o !== rx_exp.found_dev_link_id) begin
            n_err = n_err + 1;
            if (n_err <= 10) begin
              $display("result beat %0d expected deliver=%0d user_id=%0d status=%0d dev=%0d id=%h",
                       n_recv, rx_exp.deliver, rx_exp.user_id, rx_exp.status,
                       rx_exp.found_device, rx_exp.found_dev_link_id);
              $display("result beat %0d actual   deliver=%0d user_id=%0d status=%0d dev=%0d id=%h",
                       n_recv, deliver_o, user_id_o, status_o, found_device_o,
                       found_dev_link_id_o);
            end
          end
        end
      end
      if (hold_cnt != 0) begin
        out_ready_i <= 1'b0;
      end else if (rx_gap != 0) begin
        rx_gap      <= rx_gap - 1;
        out_ready_i <= 1'b0;
      end else if (rx_idle_ok && $urandom_range(0, 99) < 6) begin
        rx_gap      <= $urandom_range(0, 14);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    foreach (tbl_valid[i]) begin
      tbl_valid[i] = 1'b0;
      tbl_dev[i]   = '0;
      tbl_conn[i]  = '0;
    end
    push_req(FUNC_LOOKUP, 3'd0, 32'h0, 1'b0, 1'b0, 32'd100);
    push_req(FUNC_EVENT, 3'd0, 32'h0, 1'b1, 1'b0, 32'h0);
    push_req(FUNC_EVENT, 3'd7, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'hFFFF_FFFF);
    push_req(FUNC_EVENT, 3'd0, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0);
    push_req(FUNC_EVENT, 3'd0, 32'h0, 1'b1, 1'b0, 32'h0);
    push_req(FUNC_EVENT, 3'd7, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0);
    push_req(FUNC_LOOKUP, 3'd7, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'd100);
    push_req(FUNC_LOOKUP, 3'd0, 32'h0, 1'b0, 1'b0, 32'd101);
    push_req(FUNC_LOOKUP, 3'd0, 32'h0, 1'b0, 1'b0, 32'd99);
    push_req(FUNC_LOOKUP, 3'd0, 32'h0, 1'b0, 1'b0, ID_BASE + ENTRIES);
    push_req(FUNC_LOOKUP, 3'd0, 32'h0, 1'b0, 1'b0, 32'd0);
    push_req(FUNC_LOOKUP, 3'd0, 32'h0, 1'b0, 1'b0, 32'hFFFF_FFFF);
    push_req(FUNC_LOOKUP, 3'd0, 32'h0, 1'b0, 1'b0, ID_BASE + ENTRIES - 1);
    push_req(FUNC_LOOKUP, 3'd0, 32'h0, 1'b0, 1'b0, 32'h0000_0164);
    push_req(FUNC_EVENT, 3'd3, 32'd12345, 1'b0, 1'b0, 32'h0);
    push_req(FUNC_EVENT, 3'd0, 32'h0, 1'b0, 1'b1, 32'h0);
    push_req(FUNC_LOOKUP, 3'd0, 32'h0, 1'b0, 1'b0, 32'd100);
    push_req(FUNC_EVENT, 3'd5, 32'hA5A5_A5A5, 1'b1, 1'b0, 32'h0);
    push_req(FUNC_EVENT, 3'd2, 32'h5A5A_5A5A, 1'b1, 1'b1, 32'h0);
    push_req(FUNC_LOOKUP, 3'd0, 32'h0, 1'b0, 1'b0, 32'd103);
    push_req(FUNC_EVENT, 3'd1, 32'd77, 1'b0, 1'b1, 32'h0);
    push_req(FUNC_EVENT, 3'd7, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0);
    push_req(FUNC_LOOKUP, 3'd0, 32'h0, 1'b0, 1'b0, 32'd101);
    push_req(FUNC_LOOKUP, 3'd0, 32'h0, 1'b0, 1'b0, 32'd100);
    // fill, churn and drain rounds in turn; fill rounds run the table into its full state
    for (int r = 0; r < 15; r++) add_round(round_e'(r % 3), 120);
    n_total = pending_q.size();

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (!(n_sent == n_total && remap_expect_q.size() == 0)) @(posedge clk_i);
    repeat (ENTRIES + 16) @(posedge clk_i);
    if (n_err == 0 && remap_expect_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[filelist.f]
design/cirt_pkg.sv
design/cirt_store.sv
design/cirt_ctrl.sv
design/connection_id_remap_table.sv
bench/testbench.sv
